// File: rtl/core/iost_pkg.sv
// Package for the insertion-ordered set table.
// Holds the request codes, the sequencer states and the control bundle that
// the top level broadcasts to the row of storage cells. It depends on nothing.
package iost_pkg;

    // Width of one stored member and of the request value.
    localparam int unsigned VALUE_W = 32;

    // Width of the request kind and of the count field of a result.
    localparam int unsigned REQ_W = 2;
    localparam int unsigned COUNT_W = 5;

    // Width of the result tdata: success, rejected_full and count, padded to a byte.
    localparam int unsigned RES_W = 2 + COUNT_W;
    localparam int unsigned RES_BYTES_W = ((RES_W + 7) / 8) * 8;

    // Default number of members the table can hold.
    localparam int unsigned DEF_CAPACITY = 16;

    // Request kinds.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // Request sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    // Control bundle that every cell sees in the same cycle.
    typedef struct packed {
        logic               cmp;     // latch the compare against value
        logic               append;  // the tail cell loads value
        logic               remove;  // cells at and above the hit take their upper neighbor
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

// File: rtl/core/insertion_ordered_set_table_unit.sv
// Top level of the insertion-ordered set table: stream ports, request
// sequencer, result register and the row of iost_cell instances. Depends on
// iost_pkg and iost_cell.
//
// The block keeps up to CAPACITY distinct 32-bit values in the order they
// joined, packed from slot 0, and answers add, remove, query and clear
// requests with one result each that carries success, a full-table reject
// flag and the member count after the request. A request passes through three
// steps: it is accepted, then every cell compares its member with the
// value at once, and then the hits are combined, the tail cell
// is loaded or the cells above the hit shift down, and the result is
// registered. The next request is accepted while a result still waits to be
// taken; the apply cycle waits only when the result register is still full.
// After reset the table is empty at once, with no clearing pass.
module insertion_ordered_set_table_unit #(
    parameter int unsigned CAPACITY = iost_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [iost_pkg::VALUE_W-1:0]        i_s_axis_tdata,  // [31:0] value
    input  logic [iost_pkg::REQ_W-1:0]          i_s_axis_tuser,  // [1:0] req_type
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [iost_pkg::RES_BYTES_W-1:0]    o_m_axis_tdata   // [0] success,
                                                                 // [1] rejected_full,
                                                                 // [6:2] count, [7] zero
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    iost_pkg::t_state             r_state, n_state;
    logic [iost_pkg::REQ_W-1:0]   r_req;
    logic [iost_pkg::VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_out_valid;
    logic [iost_pkg::RES_BYTES_W-1:0] r_out_data;

    iost_pkg::t_cell_ctl          w_ctl;
    logic [CAPACITY-1:0]          w_match;
    logic [CAPACITY-1:0]          w_lower_hit;
    logic [iost_pkg::VALUE_W-1:0] w_entry [CAPACITY];
    logic                         w_found;
    logic                         w_full;
    logic                         w_apply;
    logic                         w_ok;
    logic                         w_rej;
    logic [iost_pkg::COUNT_W-1:0] w_count5;

    assign o_s_axis_tready = (r_state == iost_pkg::S_IDLE);
    assign w_apply = (r_state == iost_pkg::S_APPLY) && (!r_out_valid || i_m_axis_tready);
    assign w_found = |w_match;
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    // Request decode: the compare strobe in the compare state and the actions of the apply cycle.
    always_comb begin
        w_ctl.cmp    = (r_state == iost_pkg::S_CMP);
        w_ctl.append = 1'b0;
        w_ctl.remove = 1'b0;
        w_ctl.value  = r_value;
        w_ok         = 1'b0;
        w_rej        = 1'b0;
        n_count      = r_count;
        unique case (iost_pkg::t_req'(r_req))
            iost_pkg::REQ_ADD: begin
                if (!w_found && !w_full) begin
                    w_ctl.append = w_apply;
                    w_ok         = 1'b1;
                    n_count      = r_count + CNT_W'(1);
                end else if (!w_found) begin
                    w_rej = 1'b1;
                end
            end
            iost_pkg::REQ_REMOVE: begin
                if (w_found) begin
                    w_ctl.remove = w_apply;
                    w_ok         = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            iost_pkg::REQ_QUERY: begin
                w_ok = w_found;
            end
            iost_pkg::REQ_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // The count field carries the low five bits of the member count.
    generate
        if (CNT_W >= iost_pkg::COUNT_W) begin : g_cnt_trunc
            assign w_count5 = n_count[iost_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count5 = {{(iost_pkg::COUNT_W - CNT_W){1'b0}}, n_count};
        end
    endgenerate

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iost_pkg::S_IDLE:  if (i_s_axis_tvalid) n_state = iost_pkg::S_CMP;
            iost_pkg::S_CMP:   n_state = iost_pkg::S_APPLY;
            iost_pkg::S_APPLY: if (w_apply) n_state = iost_pkg::S_IDLE;
            default:           n_state = iost_pkg::S_IDLE;
        endcase
    end

    // Control state: sequencer, member count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iost_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_req   <= i_s_axis_tuser;
            r_value <= i_s_axis_tdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_data <= iost_pkg::RES_BYTES_W'({w_count5, w_rej, w_ok});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Row of storage cells; each sees whether any lower cell matched.
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam logic [CAPACITY-1:0] LOW_MASK =
                {CAPACITY{1'b1}} >> (CAPACITY - gi);
            logic [iost_pkg::VALUE_W-1:0] w_next;

            assign w_lower_hit[gi] = |(w_match & LOW_MASK);

            if (gi + 1 < CAPACITY) begin : g_mid
                assign w_next = w_entry[gi + 1];
            end else begin : g_top
                assign w_next = w_entry[gi];
            end

            iost_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_valid      (CNT_W'(gi) < r_count),
                .i_tail       (CNT_W'(gi) == r_count),
                .i_lower_hit  (w_lower_hit[gi]),
                .i_next_entry (w_next),
                .o_entry      (w_entry[gi]),
                .o_match      (w_match[gi])
            );
        end
    endgenerate

endmodule

// File: rtl/core/iost_cell.sv
// One storage cell of the insertion-ordered set table.
// Holds one member and its compare result, and takes its upper neighbor's
// member when a removal closes the gap. Depends on iost_pkg.
module iost_cell (
    input  logic                           i_clk,
    input  iost_pkg::t_cell_ctl            i_ctl,
    input  logic                           i_valid,      // this slot holds a member
    input  logic                           i_tail,       // this slot is the first free one
    input  logic                           i_lower_hit,  // a lower cell matched
    input  logic [iost_pkg::VALUE_W-1:0]   i_next_entry, // member of the upper neighbor
    output logic [iost_pkg::VALUE_W-1:0]   o_entry,
    output logic                           o_match
);

    logic [iost_pkg::VALUE_W-1:0] r_entry;
    logic                         r_match;
    logic                         w_shift;

    // The gap closes from the matching cell upward.
    assign w_shift = i_lower_hit | r_match;

    // Compare result, taken once per request.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= i_valid && (r_entry == i_ctl.value);
        end
    end

    // Member storage: append at the tail, or shift down on a removal.
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && i_tail) begin
            r_entry <= i_ctl.value;
        end else if (i_ctl.remove && w_shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
